### sv/prrts_pkg.sv
package prrts_pkg;

  localparam int unsigned TaskSlotsDefault = 16;

  typedef enum logic [2:0] {
    ST_UNUSED   = 3'd0,
    ST_READY    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_SLEEPING = 3'd3,
    ST_DEAD     = 3'd4
  } slot_state_e;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_CREATE = 3'd1,
    OP_KILL   = 3'd2,
    OP_SLEEP  = 3'd3,
    OP_SETPRI = 3'd4,
    OP_YIELD  = 3'd5,
    OP_EXIT   = 3'd6,
    OP_BAD    = 3'd7
  } op_e;

  localparam logic [1:0] PRIO_LOW    = 2'd0;
  localparam logic [1:0] PRIO_NORMAL = 2'd1;
  localparam logic [1:0] PRIO_HIGH   = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_REJECTED = 2'd2;

  localparam logic [1:0] CFG_Q_HIGH   = 2'd0;
  localparam logic [1:0] CFG_Q_NORMAL = 2'd1;
  localparam logic [1:0] CFG_Q_LOW    = 2'd2;

  localparam logic [63:0] FOREVER = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WAKE,
    S_SLICE,
    S_SCAN,
    S_PICK,
    S_CREATE,
    S_OP,
    S_COUNT,
    S_DONE
  } fsm_e;

endpackage

### sv/prrts_seq.sv
// Sequencer: walks one slot per cycle for wake, scan, create and live count.
module prrts_seq import prrts_pkg::*; #(
  parameter int unsigned TaskSlots = TaskSlotsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  op_e  op_i,
  input  logic slice_end_i,
  input  logic scan_hit_i,
  input  logic create_hit_i,
  input  logic hold_i,
  output fsm_e state_o,
  output logic [$clog2(TaskSlots)-1:0] idx_o,
  output logic [1:0] prio_o
);
  localparam int unsigned IW = $clog2(TaskSlots);
  localparam logic [IW-1:0] LastIdx = IW'(TaskSlots - 1);

  fsm_e state_q, state_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [1:0] prio_q, prio_d;
  logic last;

  assign last = (idx_q == LastIdx);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (op_i)
            OP_TICK:   state_d = S_WAKE;
            OP_CREATE: state_d = S_CREATE;
            default:   state_d = S_OP;
          endcase
        end
      end
      S_WAKE:   if (last) state_d = S_SLICE;
      S_SLICE:  state_d = slice_end_i ? S_SCAN : S_COUNT;
      S_SCAN: begin
        if (scan_hit_i) state_d = S_PICK;
        else if (last && prio_q == PRIO_LOW) state_d = S_PICK;
      end
      S_PICK:   state_d = S_COUNT;
      S_CREATE: if (create_hit_i || last) state_d = S_COUNT;
      S_OP:     state_d = S_COUNT;
      S_COUNT:  if (last) state_d = S_DONE;
      // hold while the previous result still waits
      S_DONE:   state_d = hold_i ? S_DONE : S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    idx_d  = idx_q;
    prio_d = prio_q;
    case (state_q)
      S_IDLE:   begin idx_d = '0; prio_d = PRIO_HIGH; end
      S_WAKE:   idx_d = idx_q + 1'b1;
      S_SLICE:  begin idx_d = '0; prio_d = PRIO_HIGH; end
      S_SCAN: begin
        idx_d = idx_q + 1'b1;
        if (last) begin
          idx_d  = '0;
          prio_d = prio_q - 1'b1;
        end
      end
      S_PICK:   idx_d = '0;
      S_CREATE: idx_d = (create_hit_i || last) ? '0 : idx_q + 1'b1;
      S_OP:     idx_d = '0;
      S_COUNT:  idx_d = idx_q + 1'b1;
      default:  idx_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      prio_q  <= PRIO_HIGH;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      prio_q  <= prio_d;
    end
  end

  assign state_o    = state_q;
  assign idx_o      = idx_q;
  assign prio_o     = prio_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !hold_i) |=> (state_q == S_IDLE))
    else $error("done not followed by idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SLICE) |=> (idx_q == '0))
    else $error("scan not started at slot zero offset");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PICK) |-> ($past(state_q) == S_SCAN))
    else $error("pick without scan");
endmodule

### sv/priority_round_robin_task_scheduler_unit.sv
// Channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall  | operation, task_id, priority_req, create_kind, sleep_ticks
// out     | out | out_valid/out_stall| running_task, switched, status, new_task, live_count
// cfg     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data (16-bit quantum registers)
//
// One word is handled at a time. A tick runs the wake sweep over all slots, the slice
// check and, if the slice has ended, a priority scan from high down to low priority
// that stops at the first ready slot, then the pick; it ends with the live count over
// all slots. Other events run the create search or the op, then the live count.
// Reset puts slot 0 running at high priority, others unused.
// in_stall is high while busy; a finished word waits in S_DONE while a result is held.
module priority_round_robin_task_scheduler_unit import prrts_pkg::*; #(
  parameter int unsigned TaskSlots = TaskSlotsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation_i,
  input  logic [3:0]  task_id_i,
  input  logic [1:0]  priority_req_i,
  input  logic        create_kind_i,
  input  logic [31:0] sleep_ticks_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  running_task_o,
  output logic        switched_o,
  output logic [1:0]  status_o,
  output logic [3:0]  new_task_o,
  output logic [4:0]  live_count_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int unsigned IW = $clog2(TaskSlots);
  localparam int unsigned CW = $clog2(TaskSlots + 1);

  // table state
  slot_state_e st_q [TaskSlots];
  logic [1:0]  pr_q [TaskSlots];
  logic [63:0] dl_q [TaskSlots];
  logic [IW-1:0] cur_q, before_q, hit_q;
  logic hit_found_q;
  logic [15:0] slice_q;
  logic [63:0] tick_q;
  logic [15:0] qh_q, qn_q, ql_q;

  // latched event word
  op_e op_q;
  logic [3:0] tid_q;
  logic [1:0] preq_q;
  logic kind_q;
  logic [31:0] sleep_q;

  logic [1:0] status_q;
  logic [3:0] created_q;
  logic [CW-1:0] live_q;

  logic out_valid_q;
  logic [3:0] run_o_q, new_o_q;
  logic sw_o_q;
  logic [1:0] stat_o_q;
  logic [4:0] live_o_q;

  fsm_e state;
  logic [IW-1:0] idx;
  logic [1:0] prio;
  logic start, busy, out_hold;
  logic slice_end, scan_hit, create_hit;
  logic [IW-1:0] scan_slot, cslot;
  logic [IW:0] scan_sum;
  logic cfg_we;

  assign busy     = (state != S_IDLE);
  assign out_hold = out_valid_q && out_stall;
  assign in_stall = busy;
  assign start    = in_valid && !busy;
  // take quantum writes only between words
  assign cfg_ready = (state == S_IDLE);
  assign cfg_we    = cfg_valid && cfg_ready;

  // Scan order: the slot after the current one, wrapping back to the current slot.
  assign scan_sum  = {1'b0, cur_q} + {1'b0, idx} + (IW+1)'(1);
  assign scan_slot = (32'(scan_sum) >= TaskSlots) ? IW'(32'(scan_sum) - TaskSlots)
                                                  : IW'(scan_sum);
  assign scan_hit  = (state == S_SCAN) && (st_q[scan_slot] == ST_READY)
                     && (pr_q[scan_slot] == prio);
  assign cslot      = IW'(32'(idx) + 32'd1);
  assign create_hit = (state == S_CREATE) && (32'(idx) + 32'd1 < TaskSlots) &&
                      ((st_q[cslot] == ST_UNUSED) || (st_q[cslot] == ST_DEAD));
  assign slice_end = (st_q[cur_q] != ST_RUNNING) || (slice_q <= 16'd1);

  prrts_seq #(.TaskSlots(TaskSlots)) u_seq (
    .clk_i, .rst_ni,
    .start_i(start), .op_i(op_e'(operation_i)),
    .slice_end_i(slice_end), .scan_hit_i(scan_hit), .create_hit_i(create_hit),
    .hold_i(out_hold),
    .state_o(state), .idx_o(idx), .prio_o(prio)
  );

  function automatic logic [15:0] quantum(input logic [1:0] p, input logic [15:0] h,
                                         input logic [15:0] n, input logic [15:0] l);
    logic [15:0] r;
    r = n;
    if (p == PRIO_HIGH) r = h;
    else if (p == PRIO_LOW) r = l;
    return r;
  endfunction

  logic tid_ok;
  assign tid_ok = (32'(tid_q) < TaskSlots);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TaskSlots; i++) begin
        st_q[i] <= (i == 0) ? ST_RUNNING : ST_UNUSED;
        pr_q[i] <= (i == 0) ? PRIO_HIGH : PRIO_NORMAL;
        dl_q[i] <= '0;
      end
      cur_q <= '0; before_q <= '0; hit_q <= '0; hit_found_q <= 1'b0;
      slice_q <= 16'd20; tick_q <= '0;
      qh_q <= 16'd20; qn_q <= 16'd10; ql_q <= 16'd5;
      op_q <= OP_TICK; tid_q <= '0; preq_q <= '0; kind_q <= 1'b0; sleep_q <= '0;
      status_q <= STAT_OK; created_q <= '0; live_q <= '0;
      out_valid_q <= 1'b0;
      run_o_q <= '0; new_o_q <= '0; sw_o_q <= 1'b0; stat_o_q <= '0; live_o_q <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_Q_HIGH:   qh_q <= cfg_data;
          CFG_Q_NORMAL: qn_q <= cfg_data;
          CFG_Q_LOW:    ql_q <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_DONE && !out_hold) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_q <= op_e'(operation_i); tid_q <= task_id_i; preq_q <= priority_req_i;
            kind_q <= create_kind_i; sleep_q <= sleep_ticks_i;
            before_q <= cur_q; status_q <= STAT_OK; created_q <= '0;
            live_q <= '0; hit_found_q <= 1'b0;
            if (op_e'(operation_i) == OP_TICK) tick_q <= tick_q + 64'd1;
            if (op_e'(operation_i) == OP_CREATE) status_q <= STAT_FULL;
          end
        end
        S_WAKE: begin
          // wake sleepers whose deadline has been reached
          if (st_q[idx] == ST_SLEEPING && tick_q >= dl_q[idx]) st_q[idx] <= ST_READY;
        end
        S_SLICE: begin
          if (st_q[cur_q] == ST_RUNNING) begin
            if (slice_q > 16'd1) slice_q <= slice_q - 16'd1;
            else begin
              slice_q <= '0;
              st_q[cur_q] <= ST_READY;
            end
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            hit_q <= scan_slot;
            hit_found_q <= 1'b1;
          end
        end
        S_PICK: begin
          if (hit_found_q) begin
            st_q[hit_q] <= ST_RUNNING;
            slice_q <= quantum(pr_q[hit_q], qh_q, qn_q, ql_q);
            cur_q <= hit_q;
          end else if (st_q[cur_q] == ST_READY) begin
            st_q[cur_q] <= ST_RUNNING;
            slice_q <= quantum(pr_q[cur_q], qh_q, qn_q, ql_q);
          end else if (st_q[0] != ST_UNUSED && st_q[0] != ST_DEAD) begin
            st_q[0] <= ST_RUNNING;
            slice_q <= quantum(pr_q[0], qh_q, qn_q, ql_q);
            cur_q <= '0;
          end
        end
        S_CREATE: begin
          if (create_hit) begin
            pr_q[cslot] <= PRIO_NORMAL;
            st_q[cslot] <= kind_q ? ST_SLEEPING : ST_READY;
            dl_q[cslot] <= kind_q ? FOREVER : 64'd0;
            created_q <= 4'(cslot);
            status_q <= STAT_OK;
          end
        end
        S_OP: begin
          case (op_q)
            OP_KILL: begin
              if (tid_q == 4'd0 || !tid_ok || st_q[IW'(tid_q)] == ST_UNUSED ||
                  st_q[IW'(tid_q)] == ST_DEAD) begin
                status_q <= STAT_REJECTED;
              end else begin
                st_q[IW'(tid_q)] <= ST_DEAD;
                if (IW'(tid_q) == cur_q) slice_q <= '0;
              end
            end
            OP_SLEEP: begin
              dl_q[cur_q] <= tick_q + {32'd0, sleep_q};
              st_q[cur_q] <= ST_SLEEPING;
              slice_q <= '0;
            end
            OP_SETPRI: begin
              if (!tid_ok || preq_q > PRIO_HIGH) status_q <= STAT_REJECTED;
              else pr_q[IW'(tid_q)] <= preq_q;
            end
            OP_YIELD: slice_q <= '0;
            OP_EXIT: begin
              if (cur_q != '0) st_q[cur_q] <= ST_DEAD;
              else status_q <= STAT_REJECTED;
              slice_q <= '0;
            end
            default: status_q <= STAT_REJECTED;
          endcase
        end
        S_COUNT: begin
          // tally live slots one per cycle
          if (st_q[idx] != ST_UNUSED && st_q[idx] != ST_DEAD) live_q <= live_q + 1'b1;
        end
        S_DONE: begin
          // load the result register once the previous word has left
          if (!out_hold) begin
            run_o_q  <= 4'(cur_q);
            sw_o_q   <= (cur_q != before_q);
            stat_o_q <= status_q;
            new_o_q  <= created_q;
            live_o_q <= 5'(live_q);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_q;
  assign running_task_o = run_o_q;
  assign switched_o     = sw_o_q;
  assign status_o       = stat_o_q;
  assign new_task_o     = new_o_q;
  assign live_count_o   = live_o_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == S_DONE) |=> out_valid)
    else $error("result not posted");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_stall) |=> (out_valid && $stable(running_task_o) && $stable(status_o)))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == S_PICK && hit_found_q) |=> (st_q[cur_q] == ST_RUNNING))
    else $error("picked slot not running");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && status_o == STAT_FULL) |-> (new_task_o == 4'd0))
    else $error("full create reported slot");
endmodule
